/* rtl/convex_hull_gift_wrap_core_assert.svh */
// assertion macros for the convex hull gift wrap core
`ifndef CONVEX_HULL_GIFT_WRAP_CORE_ASSERT_SVH
`define CONVEX_HULL_GIFT_WRAP_CORE_ASSERT_SVH
`ifndef SYNTH
`define CHGW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("chgw assertion failed");
`define CHGW_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("chgw forbidden condition seen");
`else
`define CHGW_ASSERT(lbl, prop)
`define CHGW_NEVER(lbl, cond)
`endif
`endif

/* rtl/chgw_pkg.sv */
// shared constants, types and helpers of the convex hull gift wrap core
package chgw_pkg;

	localparam int MAX_POINTS      = 64;
	localparam int COORD_WIDTH     = 16;
	localparam int MIN_HULL_POINTS = 3;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int STEP_W = 3;

	localparam logic [STEP_W-1:0] STEP_CROSS_A = 3'd0;
	localparam logic [STEP_W-1:0] STEP_CROSS_B = 3'd1;
	localparam logic [STEP_W-1:0] STEP_DOT_A   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DOT_B   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_DECIDE  = 3'd4;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MIN_RD,
		S_MIN_CHK,
		S_DIFF_RD,
		S_DIFF_CHK,
		S_SW_RD,
		S_SW_LD,
		S_SW_MUL,
		S_SW_END,
		S_FLUSH
	} state_t;

	// lexicographic order on x, then y
	function automatic logic lex_less(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		return (ax < bx) || ((ax == bx) && (ay < by));
	endfunction

endpackage

/* rtl/chgw_ram.sv */
// generic single write port ram with registered read
module chgw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/convex_hull_gift_wrap_core.sv */
// convex hull gift wrap core: point store, start search and wrap sequencer
//
// Points are taken one per cycle while busy is low; the point with last_point
// set closes the set and starts the walk (with fewer than three points it gives
// one empty result instead), and busy stays high until the final result.
// Results come as one-cycle strobes on result_valid and cannot be held off. The
// start search reads every stored point once, and each hull vertex takes a
// search for the first point that differs from it plus a sweep over all points;
// the sweep pace is set by the single store read port and the one shared 17x17
// multiplier, which forms both cross and both dot product terms of each point in turn.
`include "convex_hull_gift_wrap_core_assert.svh"

module convex_hull_gift_wrap_core
	import chgw_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic                          last_point,
	output logic                          result_valid,
	output logic signed [COORD_WIDTH-1:0] vertex_x,
	output logic signed [COORD_WIDTH-1:0] vertex_y,
	output logic                          vertex_last,
	output logic                          hull_empty,
	output logic                          points_dropped
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic [IDX_W-1:0]  idx_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  emit_cnt_q;

	coord_t start_x_q, start_y_q, cur_x_q, cur_y_q, cand_x_q, cand_y_q;
	coord_t pend_x_q, pend_y_q, p_x_q, p_y_q;
	diff_t  dx1_q, dy1_q, dx2_q, dy2_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q, cross_q;

	logic                     result_valid_q;
	coord_t                   vertex_x_q, vertex_y_q;
	logic                     vertex_last_q, hull_empty_q, points_dropped_q;

	logic [2*COORD_WIDTH-1:0] ram_rdata;
	coord_t                   rd_x, rd_y;

	logic              accept;
	logic              room;
	logic [CNT_W-1:0]  cnt_next;
	logic              ovf_next;
	logic              too_few;
	logic [IDX_W-1:0]  last_idx;
	logic              idx_last;
	logic              emit_cap;
	logic              min_take;
	coord_t            min_x, min_y;
	logic              differs;
	logic              back_at_start;

	diff_t                    mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ACC_W-1:0]  dot_w;
	logic                     replace;

	logic   ram_we;
	logic   emit_en;
	logic   emit_last;
	logic   emit_empty;
	logic   emit_drop;
	coord_t emit_x, emit_y;

	assign accept   = start && !busy;
	assign room     = cnt_q < CNT_W'(MAX_POINTS);
	assign cnt_next = room ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	assign ovf_next = ovf_q || !room;
	assign too_few  = cnt_next < CNT_W'(MIN_HULL_POINTS);
	assign last_idx = IDX_W'(cnt_q - 1'b1);
	assign idx_last = idx_q == last_idx;
	assign emit_cap = CNT_W'(emit_cnt_q + 1'b1) == CNT_W'(MAX_POINTS);

	assign rd_x = ram_rdata[COORD_WIDTH-1:0];
	assign rd_y = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];

	assign min_take = (idx_q == '0) || lex_less(rd_x, rd_y, start_x_q, start_y_q);
	assign min_x    = min_take ? rd_x : start_x_q;
	assign min_y    = min_take ? rd_y : start_y_q;
	assign differs  = (rd_x != cand_x_q) || (rd_y != cand_y_q);
	assign back_at_start = (cand_x_q == start_x_q) && (cand_y_q == start_y_q);

	chgw_ram #(
		.WIDTH(2 * COORD_WIDTH),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata({point_y, point_x}),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// shared multiplier operand select
	always_comb begin
		case (step_q)
			STEP_CROSS_A: begin
				mul_a = dx1_q;
				mul_b = dy2_q;
			end
			STEP_CROSS_B: begin
				mul_a = dx2_q;
				mul_b = dy1_q;
			end
			STEP_DOT_A: begin
				mul_a = dx1_q;
				mul_b = dx2_q;
			end
			STEP_DOT_B: begin
				mul_a = dy1_q;
				mul_b = dy2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign dot_w   = acc_q + ACC_W'(prod_q);
	assign replace = (cross_q == '0) ? (dot_w > 0) : (cross_q > 0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && last_point && !too_few) begin
					state_d = S_MIN_RD;
				end
			end
			S_MIN_RD:   state_d = S_MIN_CHK;
			S_MIN_CHK:  state_d = idx_last ? S_DIFF_RD : S_MIN_RD;
			S_DIFF_RD:  state_d = S_DIFF_CHK;
			S_DIFF_CHK: state_d = (differs || idx_last) ? S_SW_RD : S_DIFF_RD;
			S_SW_RD:    state_d = S_SW_LD;
			S_SW_LD:    state_d = S_SW_MUL;
			S_SW_MUL: begin
				if (step_q == STEP_DECIDE) begin
					state_d = idx_last ? S_SW_END : S_SW_RD;
				end
			end
			S_SW_END: begin
				if (back_at_start) begin
					state_d = S_IDLE;
				end else begin
					state_d = emit_cap ? S_FLUSH : S_DIFF_RD;
				end
			end
			S_FLUSH:    state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy       = 1'b1;
		ram_we     = 1'b0;
		emit_en    = 1'b0;
		emit_last  = 1'b0;
		emit_empty = 1'b0;
		emit_drop  = ovf_q;
		emit_x     = pend_x_q;
		emit_y     = pend_y_q;
		unique case (state_q)
			S_IDLE: begin
				busy   = 1'b0;
				ram_we = accept && room;
				if (accept && last_point && too_few) begin
					emit_en    = 1'b1;
					emit_last  = 1'b1;
					emit_empty = 1'b1;
					emit_drop  = ovf_next;
					emit_x     = '0;
					emit_y     = '0;
				end
			end
			S_SW_END: begin
				emit_en   = 1'b1;
				emit_last = back_at_start;
			end
			S_FLUSH: begin
				emit_en   = 1'b1;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
			idx_q          <= '0;
			step_q         <= STEP_CROSS_A;
			emit_cnt_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= emit_en;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						if (last_point && too_few) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							cnt_q <= cnt_next;
							ovf_q <= ovf_next;
						end
					end
				end
				S_MIN_CHK: begin
					if (idx_last) begin
						idx_q      <= '0;
						emit_cnt_q <= CNT_W'(1);
					end else begin
						idx_q <= IDX_W'(idx_q + 1'b1);
					end
				end
				S_DIFF_CHK: begin
					idx_q <= (differs || idx_last) ? '0 : IDX_W'(idx_q + 1'b1);
				end
				S_SW_RD: begin
					step_q <= STEP_CROSS_A;
				end
				S_SW_MUL: begin
					step_q <= STEP_W'(step_q + 1'b1);
					if (step_q == STEP_DECIDE) begin
						idx_q <= idx_last ? '0 : IDX_W'(idx_q + 1'b1);
					end
				end
				S_SW_END: begin
					idx_q <= '0;
					if (back_at_start) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						emit_cnt_q <= CNT_W'(emit_cnt_q + 1'b1);
					end
				end
				S_FLUSH: begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_MIN_CHK: begin
				start_x_q <= min_x;
				start_y_q <= min_y;
				if (idx_last) begin
					cur_x_q  <= min_x;
					cur_y_q  <= min_y;
					cand_x_q <= min_x;
					cand_y_q <= min_y;
					pend_x_q <= min_x;
					pend_y_q <= min_y;
				end
			end
			S_DIFF_CHK: begin
				if (differs) begin
					cand_x_q <= rd_x;
					cand_y_q <= rd_y;
				end
			end
			S_SW_LD: begin
				p_x_q <= rd_x;
				p_y_q <= rd_y;
				dx1_q <= DIFF_W'(cand_x_q) - DIFF_W'(cur_x_q);
				dy1_q <= DIFF_W'(cand_y_q) - DIFF_W'(cur_y_q);
				dx2_q <= DIFF_W'(rd_x) - DIFF_W'(cand_x_q);
				dy2_q <= DIFF_W'(rd_y) - DIFF_W'(cand_y_q);
			end
			S_SW_MUL: begin
				prod_q <= mul_p;
				case (step_q)
					STEP_CROSS_B: acc_q <= ACC_W'(prod_q);
					STEP_DOT_A:   cross_q <= acc_q - ACC_W'(prod_q);
					STEP_DOT_B:   acc_q <= ACC_W'(prod_q);
					STEP_DECIDE: begin
						if (replace) begin
							cand_x_q <= p_x_q;
							cand_y_q <= p_y_q;
						end
					end
					default: begin
					end
				endcase
			end
			S_SW_END: begin
				if (!back_at_start) begin
					cur_x_q  <= cand_x_q;
					cur_y_q  <= cand_y_q;
					pend_x_q <= cand_x_q;
					pend_y_q <= cand_y_q;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (emit_en) begin
			vertex_x_q       <= emit_x;
			vertex_y_q       <= emit_y;
			vertex_last_q    <= emit_last;
			hull_empty_q     <= emit_empty;
			points_dropped_q <= emit_drop;
		end
	end

	assign result_valid   = result_valid_q;
	assign vertex_x       = vertex_x_q;
	assign vertex_y       = vertex_y_q;
	assign vertex_last    = vertex_last_q;
	assign hull_empty     = hull_empty_q;
	assign points_dropped = points_dropped_q;

	`CHGW_ASSERT(a_walk_has_points, (state_q != S_IDLE) |-> (cnt_q >= CNT_W'(MIN_HULL_POINTS)))
	`CHGW_NEVER(a_emit_cap, emit_cnt_q > CNT_W'(MAX_POINTS))
	`CHGW_ASSERT(a_last_frees_block, (result_valid && vertex_last) |-> !busy)
	`CHGW_ASSERT(a_more_follow, (result_valid && !vertex_last) |-> busy)
	`CHGW_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start))

endmodule
